// ----- hdl/ple_pkg.sv -----
package ple_pkg;

   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND     = 3'd0,
      OP_INSERT     = 3'd1,
      OP_REMOVE_HD  = 3'd2,
      OP_REMOVE_AT  = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_CLEAR      = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_NULL   = 3'd1,
      ST_BADPOS = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_POS,
      PTR_LAST,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   // Commands from the sequencer to the datapath, valid for one cycle.
   typedef struct packed {
      logic       load;
      ptr_op_type ptr_op;
      logic       rd_shift;
      logic       rd_shift_up;
      logic       rd_take;
      logic       rd_cmp;
      logic       wr_item;
      logic       wr_at_count;
      logic       set_status;
      status_type status;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       finish;
   } ctl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       item_null;
      logic       cnt_zero;
      logic       cnt_full;
      logic       pos_gt_cnt;
      logic       pos_ge_cnt;
      logic       ptr_at_pos;
      logic       ptr_at_last;
      logic       hit;
      logic       out_free;
   } dp_sts_type;

endpackage

// ----- hdl/ple_ram.sv -----
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/ple_ctrl.sv -----
module ple_ctrl
   import ple_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_SHIFT,
      S_INS_FLUSH,
      S_INS_PUT,
      S_REM_FIRST,
      S_REM_SHIFT,
      S_REM_FLUSH,
      S_SRCH_RD,
      S_SRCH_END,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.ptr_op = PTR_HOLD;
      cmd.status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (sts.op)
               OP_APPEND: begin
                  if (sts.item_null) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NULL;
                  end else if (sts.cnt_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.wr_item     = 1'b1;
                     cmd.wr_at_count = 1'b1;
                     cmd.cnt_inc     = 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (sts.item_null) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NULL;
                  end else if (sts.pos_gt_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BADPOS;
                  end else if (sts.cnt_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else if (sts.pos_ge_cnt) begin
                     // Insert at the tail: nothing to move.
                     cmd.wr_item = 1'b1;
                     cmd.cnt_inc = 1'b1;
                  end else begin
                     cmd.ptr_op = PTR_LAST;
                     state_in   = S_INS_SHIFT;
                  end
               end
               OP_REMOVE_HD: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     state_in   = S_REM_FIRST;
                  end
               end
               OP_REMOVE_AT: begin
                  if (sts.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else if (sts.pos_ge_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_BADPOS;
                  end else begin
                     cmd.ptr_op = PTR_POS;
                     state_in   = S_REM_FIRST;
                  end
               end
               OP_SEARCH: begin
                  if (sts.item_null) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NULL;
                  end else if (!sts.cnt_zero) begin
                     cmd.ptr_op = PTR_ZERO;
                     state_in   = S_SRCH_RD;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_INS_SHIFT: begin
            // Entries move up one place, walking from the tail down to the position.
            cmd.rd_shift    = 1'b1;
            cmd.rd_shift_up = 1'b1;
            if (sts.ptr_at_pos) begin
               state_in = S_INS_FLUSH;
            end else begin
               cmd.ptr_op = PTR_DEC;
            end
         end
         S_INS_FLUSH: begin
            state_in = S_INS_PUT;
         end
         S_INS_PUT: begin
            cmd.wr_item = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = S_DONE;
         end
         S_REM_FIRST: begin
            cmd.rd_take = 1'b1;
            if (sts.ptr_at_last) begin
               state_in = S_REM_FLUSH;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_REM_SHIFT;
            end
         end
         S_REM_SHIFT: begin
            cmd.rd_shift = 1'b1;
            if (sts.ptr_at_last) begin
               state_in = S_REM_FLUSH;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_REM_FLUSH: begin
            cmd.cnt_dec = 1'b1;
            state_in    = S_DONE;
         end
         S_SRCH_RD: begin
            if (sts.hit) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_cmp = 1'b1;
               if (sts.ptr_at_last) begin
                  state_in = S_SRCH_END;
               end else begin
                  cmd.ptr_op = PTR_INC;
               end
            end
         end
         S_SRCH_END: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/ple_dp.sv -----
module ple_dp
   import ple_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ITEM_W = 32,
   localparam int POS_W  = $clog2(DEPTH + 1),
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_sts_type          sts,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ITEM_W-1:0]   req_item,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ITEM_W-1:0]   rsp_removed_item,
   output logic                rsp_found,
   output logic [ADDR_W-1:0]   rsp_found_position,
   output logic [POS_W-1:0]    rsp_length
);

   logic [OPCODE_W-1:0] opcode_ff;
   logic [ITEM_W-1:0]   item_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    count_ff;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic                pend_ff, pend_up_ff, cap_ff, cmp_ff;
   status_type          status_ff;
   logic [ITEM_W-1:0]   removed_ff;
   logic                found_ff;
   logic [ADDR_W-1:0]   fpos_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ITEM_W-1:0]   rsp_removed_ff;
   logic                rsp_found_ff;
   logic [ADDR_W-1:0]   rsp_fpos_ff;
   logic [POS_W-1:0]    rsp_length_ff;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ITEM_W-1:0]   ram_wdata;
   logic [ITEM_W-1:0]   ram_rdata;
   logic                hit;

   ple_ram #(
      .WIDTH (ITEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   // A shift read lands in the next cycle and is written one place up or down.
   always_comb begin
      ram_we    = pend_ff | cmd.wr_item;
      ram_wdata = item_ff;
      ram_waddr = cmd.wr_at_count ? ADDR_W'(count_ff) : ADDR_W'(pos_ff);
      if (pend_ff) begin
         ram_wdata = ram_rdata;
         ram_waddr = pend_up_ff ? rd_addr_ff + ADDR_W'(1) : rd_addr_ff - ADDR_W'(1);
      end
   end

   assign hit = cmp_ff && (ram_rdata == item_ff);

   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ZERO: ptr_in = '0;
         PTR_POS:  ptr_in = ADDR_W'(pos_ff);
         PTR_LAST: ptr_in = ADDR_W'(count_ff - POS_W'(1));
         PTR_INC:  ptr_in = ptr_ff + ADDR_W'(1);
         PTR_DEC:  ptr_in = ptr_ff - ADDR_W'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.rd_shift;
         cap_ff  <= cmd.rd_take;
         cmp_ff  <= cmd.rd_cmp;
         if (cmd.cnt_clr) begin
            count_ff <= '0;
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + POS_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - POS_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      rd_addr_ff <= ptr_ff;
      pend_up_ff <= cmd.rd_shift_up;
      if (cmd.load) begin
         opcode_ff  <= req_opcode;
         item_ff    <= req_item;
         pos_ff     <= req_position;
         status_ff  <= ST_OK;
         removed_ff <= '0;
         found_ff   <= 1'b0;
         fpos_ff    <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cap_ff) begin
            removed_ff <= ram_rdata;
         end
         // Only the first match counts; a read still in flight is ignored.
         if (hit && !found_ff) begin
            found_ff <= 1'b1;
            fpos_ff  <= rd_addr_ff;
         end
      end
      if (cmd.finish) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_found_ff   <= found_ff;
         rsp_fpos_ff    <= fpos_ff;
         rsp_length_ff  <= count_ff;
      end
   end

   always_comb begin
      sts.op          = opcode_type'(opcode_ff);
      sts.item_null   = (item_ff == '0);
      sts.cnt_zero    = (count_ff == '0);
      sts.cnt_full    = (count_ff == POS_W'(DEPTH));
      sts.pos_gt_cnt  = (pos_ff > count_ff);
      sts.pos_ge_cnt  = (pos_ff >= count_ff);
      sts.ptr_at_pos  = (POS_W'(ptr_ff) == pos_ff);
      sts.ptr_at_last = (POS_W'(ptr_ff) + POS_W'(1) == count_ff);
      sts.hit         = hit;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_item   = rsp_removed_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_length         = rsp_length_ff;

endmodule

// ----- hdl/positional_list_engine.sv -----
// Ordered list of up to DEPTH nonzero handles, kept head to tail in one
// dual-port RAM. Each request transfer on the req_ channel carries one of six
// operations (append, insert at position, remove head, remove at position,
// search, clear) in req_tuser, and each produces exactly one transfer on the
// rsp_ channel with a status code in rsp_tuser and the removed handle, search
// result and new length in rsp_tdata.
// Requests are handled one at a time. Append, clear, searches on an empty list
// and all rejected requests go from decode straight to the response. Insert
// and remove move the entries from the position to the tail, and search reads
// from the head until a match or the tail, one entry per cycle through the
// RAM's single read and write port.
// The controller goes idle as the previous response is loaded, so the next
// request can be accepted even while that response still waits in the output
// register. If the receiver holds rsp_tready low, a finished operation waits
// until the output register is free, and req_tready stays low meanwhile.
// Synchronous reset empties the list and drops any pending response; stored
// handles are not cleared, since only entries below the length are ever read.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ITEM_W = 32,
   localparam int POS_W  = $clog2(DEPTH + 1),
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int REQ_W  = ((ITEM_W + POS_W + 7) / 8) * 8,
   localparam int RSP_W  = ((ITEM_W + 1 + ADDR_W + POS_W + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // item, position
   input  logic [OPCODE_W-1:0] req_tuser,   // opcode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // removed_item, found, found_position, length
   output logic [STATUS_W-1:0] rsp_tuser    // status
);

   ctl_cmd_type       cmd;
   dp_sts_type        sts;
   logic [ITEM_W-1:0] removed_item;
   logic              found;
   logic [ADDR_W-1:0] found_position;
   logic [POS_W-1:0]  length;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ple_dp #(
      .DEPTH  (DEPTH),
      .ITEM_W (ITEM_W)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_tuser),
      .req_item           (req_tdata[ITEM_W-1:0]),
      .req_position       (req_tdata[ITEM_W +: POS_W]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_status         (rsp_tuser),
      .rsp_removed_item   (removed_item),
      .rsp_found          (found),
      .rsp_found_position (found_position),
      .rsp_length         (length)
   );

   assign rsp_tdata = RSP_W'({length, found_position, found, removed_item});

endmodule

// ----- hdl/ple_checker.sv -----
module ple_checker
   import ple_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ITEM_W = 32,
   localparam int POS_W  = $clog2(DEPTH + 1),
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int REQ_W  = ((ITEM_W + POS_W + 7) / 8) * 8,
   localparam int RSP_W  = ((ITEM_W + 1 + ADDR_W + POS_W + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [REQ_W-1:0]    req_tdata,
   input logic [OPCODE_W-1:0] req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_W-1:0]    rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser
);

   logic [ITEM_W-1:0] removed_item;
   logic              found;
   logic [POS_W-1:0]  length;

   assign removed_item = rsp_tdata[ITEM_W-1:0];
   assign found        = rsp_tdata[ITEM_W];
   assign length       = rsp_tdata[ITEM_W + 1 + ADDR_W +: POS_W];

   // A stalled response must hold until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> length <= POS_W'(DEPTH))
      else $error("length above capacity");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> removed_item == '0 && !found)
      else $error("rejected request reports a handle");

   // A request is only taken when no earlier one is still being worked on.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind positional_list_engine ple_checker #(
   .DEPTH  (DEPTH),
   .ITEM_W (ITEM_W)
) u_ple_checker (.*);

// ----- test/tb_positional_list_engine.sv -----
module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int DEPTH = 16;
   localparam int ITEMS = 600;
   localparam int LIMIT = 200000;
   localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      status_type status;
      bit [31:0]  removed;
      bit         found;
      bit [3:0]   found_pos;
      bit [4:0]   length;
   } list_outcome_type;

   class list_scoreboard;
      bit [31:0]        handles[$];
      list_outcome_type responses_due[$];
      int               errors;

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch: %s got %0h expected %0h", what, got, want);
         errors++;
      endtask

      // Applies one accepted request to the list copy and queues its response.
      function void apply_request(logic [OPCODE_W-1:0] op, bit [31:0] item, bit [4:0] pos);
         list_outcome_type r;
         int               n;
         r.status = ST_OK;
         r.removed = '0;
         r.found = 1'b0;
         r.found_pos = '0;
         n = handles.size();
         case (op)
            OP_APPEND: begin
               if (item == 0) r.status = ST_NULL;
               else if (n >= DEPTH) r.status = ST_FULL;
               else handles.push_back(item);
            end
            OP_INSERT: begin
               if (item == 0) r.status = ST_NULL;
               else if (pos > n) r.status = ST_BADPOS;
               else if (n >= DEPTH) r.status = ST_FULL;
               else handles.insert(pos, item);
            end
            OP_REMOVE_HD: begin
               if (n == 0) r.status = ST_EMPTY;
               else r.removed = handles.pop_front();
            end
            OP_REMOVE_AT: begin
               if (n == 0) r.status = ST_EMPTY;
               else if (pos >= n) r.status = ST_BADPOS;
               else begin
                  r.removed = handles[pos];
                  handles.delete(pos);
               end
            end
            OP_SEARCH: begin
               if (item == 0) r.status = ST_NULL;
               else begin
                  for (int i = 0; i < n; i++) begin
                     if (handles[i] == item) begin
                        r.found = 1'b1;
                        r.found_pos = 4'(i);
                        break;
                     end
                  end
               end
            end
            OP_CLEAR: handles.delete();
            default: ;
         endcase
         r.length = 5'(handles.size());
         responses_due.push_back(r);
      endfunction

      task check_response(logic [STATUS_W-1:0] st, logic [47:0] d);
         list_outcome_type r;
         if (responses_due.size() == 0) begin
            report("response with none outstanding", d[31:0], 0);
         end else begin
            r = responses_due.pop_front();
            if (st !== r.status) report("status", st, r.status);
            if (d[31:0] !== r.removed) report("removed_item", d[31:0], r.removed);
            if (d[32] !== r.found) report("found", d[32], r.found);
            if (d[36:33] !== r.found_pos) report("found_position", d[36:33], r.found_pos);
            if (d[41:37] !== r.length) report("length", d[41:37], r.length);
            if (d[47:42] !== '0) report("tdata padding", d[47:42], 0);
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [39:0]         req_tdata;   // item, position
   logic [OPCODE_W-1:0] req_tuser;   // opcode
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [47:0]         rsp_tdata;   // removed_item, found, found_position, length
   logic [STATUS_W-1:0] rsp_tuser;   // status

   list_scoreboard sb = new();
   bit             no_idle;
   int             cycles;
   bit [31:0]      handle_pool[8] = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h2, 32'hDEAD_BEEF};

   positional_list_engine uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("tb_positional_list_engine: done, errors");
         $finish;
      end
   end

   // Offers one request and returns at the edge where it is transferred.
   task drive_request(input logic [OPCODE_W-1:0] op, input bit [31:0] item, input bit [4:0] pos);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, pos, item};
      do @(posedge clock); while (!req_tready);
      sb.apply_request(op, item, pos);
   endtask

   function bit [31:0] pick_handle();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 8) return 32'h0;
      if (sel < 55) return handle_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Receiver: random stalls, one long hold-off, no stalls while no_idle is set.
   initial begin
      int stall;
      int taken;
      bit held;
      taken = 0;
      held = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!held && taken == 150) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tuser, rsp_tdata);
         taken++;
      end
   end

   initial begin
      int            n;
      int            sel;
      bit            growing;
      logic [OPCODE_W-1:0] op;
      bit [31:0]     item;
      bit [4:0]      pos;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_APPEND;
      rsp_tready = 1'b1;
      no_idle = 1'b0;
      cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty list, null handles and an insert past the end.
      drive_request(OP_REMOVE_HD, 32'h0, 5'd0);
      drive_request(OP_REMOVE_AT, 32'h0, 5'd0);
      drive_request(OP_SEARCH, 32'hFFFF_FFFF, 5'd0);
      drive_request(OP_APPEND, 32'h0, 5'd0);
      drive_request(OP_INSERT, 32'h0, 5'd0);
      drive_request(OP_SEARCH, 32'h0, 5'd0);
      drive_request(OP_INSERT, 32'h1234_5678, 5'd1);
      // Fill to capacity, alternating mid-list inserts, inserts at the tail and appends.
      for (int k = 0; k < DEPTH; k++) begin
         item = (k == DEPTH - 1) ? 32'hFFFF_FFFF : (32'h1 << (2 * k));
         if (k % 2 == 1) drive_request(OP_APPEND, item, 5'd31);
         else drive_request(OP_INSERT, item, (k % 4 == 0) ? 5'(k / 2) : 5'(k));
      end
      drive_request(OP_APPEND, 32'h8000_0000, 5'd0);
      drive_request(OP_INSERT, 32'h8000_0000, 5'd16);
      drive_request(OP_SEARCH, 32'h1 << 10, 5'd0);
      drive_request(OP_SEARCH, 32'h1234_5678, 5'd0);
      drive_request(OP_REMOVE_AT, 32'h0, 5'd16);
      drive_request(OP_REMOVE_AT, 32'h0, 5'd15);
      drive_request(OP_REMOVE_AT, 32'h0, 5'd0);
      drive_request(OP_REMOVE_HD, 32'h0, 5'd0);
      drive_request(OP_SPARE_6, 32'hFFFF_FFFF, 5'd16);
      drive_request(OP_SPARE_7, 32'h0, 5'd0);
      drive_request(OP_CLEAR, 32'h0, 5'd0);

      growing = 1'b1;
      for (int k = 0; k < ITEMS; k++) begin
         // Hold the sender until the block has drained everything.
         if (k == 300) begin
            req_tvalid <= 1'b0;
            while (sb.responses_due.size() != 0) @(posedge clock);
         end
         no_idle = (k >= 420 && k < 500);
         n = sb.handles.size();
         if (growing && n == DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
         else if (!growing && n == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
         sel = $urandom_range(0, 99);
         // Growing favors append and insert, shrinking favors the removes.
         if (sel < 2) op = OP_CLEAR;
         else if (sel < 4) op = (sel == 2) ? OP_SPARE_6 : OP_SPARE_7;
         else if (sel < 16) op = OP_SEARCH;
         else if (growing) op = (sel < 50) ? OP_APPEND : (sel < 84) ? OP_INSERT :
                                (sel < 90) ? OP_REMOVE_HD : OP_REMOVE_AT;
         else op = (sel < 26) ? OP_APPEND : (sel < 36) ? OP_INSERT :
                   (sel < 68) ? OP_REMOVE_HD : OP_REMOVE_AT;
         item = pick_handle();
         if (op == OP_SEARCH && n > 0 && $urandom_range(0, 1) == 1)
            item = sb.handles[$urandom_range(0, n - 1)];
         if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 16));
         else pos = 5'($urandom_range(0, n + 1 > 16 ? 16 : n + 1));
         drive_request(op, item, pos);
      end
      req_tvalid <= 1'b0;

      while (sb.responses_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_positional_list_engine: done, clean");
      end else begin
         $display("tb_positional_list_engine: done, errors");
      end
      $finish;
   end

endmodule
